// ----- src/gstm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gravity time-step minimum: shared package
// Field widths, configuration register indexes and dimension codes used by
// the channel interfaces and the core.
// ----------------------------------------------------------------------------
package gstm_pkg;

  // Payload widths.
  localparam int unsigned SpeedW = 32;  // sound speed, unsigned Q16.16
  localparam int unsigned GrunW  = 16;  // Gruneisen parameter, unsigned Q4.12
  localparam int unsigned DtW    = 32;  // time step, unsigned Q16.16
  localparam int unsigned GravW  = 24;  // gravity component, signed Q8.16

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = GravW;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_GRAVITY_ENABLE = 3'd0;
  localparam cfg_idx_t CFG_NUM_DIMS       = 3'd1;
  localparam cfg_idx_t CFG_GRAVITY_X      = 3'd2;
  localparam cfg_idx_t CFG_GRAVITY_Y      = 3'd3;
  localparam cfg_idx_t CFG_GRAVITY_Z      = 3'd4;

  // Problem dimension codes. Zero is handled like one dimension.
  typedef logic [1:0] dims_t;

  localparam dims_t DIMS_1D = 2'd1;
  localparam dims_t DIMS_2D = 2'd2;
  localparam dims_t DIMS_3D = 2'd3;

endpackage

// ----- src/gstm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gravity time-step minimum: channel interfaces
// Valid/ready channels for cell requests, result requests and register writes.
// ----------------------------------------------------------------------------

// Cell request channel.
interface gstm_in_if import gstm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SpeedW-1:0] cell_speed;
  logic [GrunW-1:0]  gruneisen;
  logic              last_cell;

  modport source (output valid, output cell_speed, output gruneisen, output last_cell,
                  input ready);
  modport sink   (input valid, input cell_speed, input gruneisen, input last_cell,
                  output ready);
endinterface

// Result request channel.
interface gstm_out_if import gstm_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [DtW-1:0] dt_stable;
  logic           unlimited;

  modport source (output valid, output dt_stable, output unlimited, input ready);
  modport sink   (input valid, input dt_stable, input unlimited, output ready);
endinterface

// Register write channel.
interface gstm_cfg_if import gstm_pkg::*; ();
  logic                valid;
  logic                ready;
  cfg_idx_t            index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/gravity_stable_timestep_min_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gravity time-step minimum core
// Running minimum of c / (|g| * sqrt(2*G*(G+1))) over a patch of cells,
// computed with a bit-serial multiplier, square root and divider.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Payload                              | Accepted when
//  ---------+-----------+--------------------------------------+----------------------
//  cfg_i    | in        | index (3 b), data (24 b)             | valid & ready
//  in_i     | in        | cell_speed, gruneisen, last_cell     | valid & ready
//  out_o    | out       | dt_stable, unlimited                 | valid & ready
//
// Sequence: while gravity is enabled a cell passes through G*(G+1), its
// root, the denominator product and the quotient, one bit per cycle each,
// plus the zero and saturation checks and the update of the minimum. The first
// cell after a gravity or dimension write also forms |g| in 2D or 3D: the
// squares, then their root. With gravity disabled a cell goes straight to FIN.
// Reset: asynchronous, active low; the minimum returns to all ones and the
// configuration registers to gravity disabled, one dimension and zero gravity.
// Stalls: a new cell is taken while a result waits on out_o; only a second
// result that finds the output register still full holds the core.
// ----------------------------------------------------------------------------
module gravity_stable_timestep_min_core import gstm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  gstm_cfg_if.sink   cfg_i,
  gstm_in_if.sink    in_i,
  gstm_out_if.source out_o
);

  // Sequencer states. Each arithmetic phase reuses one of the serial units.
  localparam logic [3:0] ST_IDLE  = 4'd0;   // waiting for a cell
  localparam logic [3:0] ST_SQX   = 4'd1;   // accumulate gx^2
  localparam logic [3:0] ST_SQY   = 4'd2;   // accumulate gy^2
  localparam logic [3:0] ST_SQZ   = 4'd3;   // accumulate gz^2
  localparam logic [3:0] ST_GROOT = 4'd4;   // |g| = sqrt(sum of squares)
  localparam logic [3:0] ST_GMUL  = 4'd5;   // G * (G + 1)
  localparam logic [3:0] ST_SROOT = 4'd6;   // s = sqrt(2 * G * (G + 1))
  localparam logic [3:0] ST_DEN   = 4'd7;   // den = |g| * s
  localparam logic [3:0] ST_DCHK  = 4'd8;   // zero and saturation checks
  localparam logic [3:0] ST_DIV   = 4'd9;   // dt = c * 2^28 / den
  localparam logic [3:0] ST_UPD   = 4'd10;  // fold dt into the minimum
  localparam logic [3:0] ST_FIN   = 4'd11;  // emit the result on a last cell

  localparam logic [5:0] MulSqCycles = 6'd24;
  localparam logic [5:0] MulGCycles  = 6'd16;
  localparam logic [5:0] RootGCycles = 6'd24;
  localparam logic [5:0] RootSCycles = 6'd17;
  localparam logic [5:0] MulDCycles  = 6'd17;
  localparam logic [5:0] DivCycles   = 6'd32;

  localparam logic [16:0] GrunOne = 17'd4096;  // 1.0 in Q4.12

  function automatic logic [GravW-1:0] abs24(input logic [GravW-1:0] v);
    abs24 = v[GravW-1] ? (~v + 1'b1) : v;
  endfunction

  // Configuration registers.
  logic             en_q, en_d;
  dims_t            dims_q, dims_d;
  logic [GravW-1:0] gx_q, gx_d, gy_q, gy_d, gz_q, gz_d;

  // Control state.
  logic [3:0]       state_q, state_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             gmag_vld_q, gmag_vld_d;
  logic [DtW-1:0]   min_q, min_d;
  logic             seen_q, seen_d;
  logic             out_vld_q, out_vld_d;

  // Datapath registers.
  logic [SpeedW-1:0] c_q, c_d;
  logic [GrunW-1:0]  gru_q, gru_d;
  logic              last_q, last_d;
  logic [47:0]       mc_q, mc_d;       // multiplicand, shifts left
  logic [23:0]       mp_q, mp_d;       // multiplier, shifts right
  logic [47:0]       acc_q, acc_d;     // product accumulator
  logic [47:0]       rad_q, rad_d;     // radicand, two bits leave per cycle
  logic [25:0]       rem_q, rem_d;     // root remainder
  logic [23:0]       root_q, root_d;
  logic [23:0]       gmag_q, gmag_d;   // |g|, Q8.16
  logic [40:0]       den_q, den_d;     // Q.28
  logic [40:0]       drem_q, drem_d;   // partial remainder of the quotient
  logic [3:0]        dbits_q, dbits_d; // low dividend bits still to shift in
  logic [DtW-1:0]    quo_q, quo_d;
  logic [DtW-1:0]    out_dt_q, out_dt_d;
  logic              out_unl_q, out_unl_d;

  // Serial multiplier step.
  logic [47:0] mul_acc;
  logic        step_last;
  assign mul_acc   = acc_q + (mp_q[0] ? mc_q : 48'd0);
  assign step_last = (cnt_q == 6'd1);

  // Restoring square root step.
  logic [27:0] rt_part, rt_trial, rt_diff;
  logic        rt_ge;
  logic [23:0] rt_root;
  assign rt_part  = {rem_q, rad_q[47:46]};
  assign rt_trial = {2'b00, root_q, 2'b01};
  assign rt_ge    = (rt_part >= rt_trial);
  assign rt_diff  = rt_ge ? (rt_part - rt_trial) : rt_part;
  assign rt_root  = {root_q[22:0], rt_ge};

  // Restoring division step.
  logic [41:0] dv_part, dv_diff;
  logic        dv_ge;
  assign dv_part = {drem_q, dbits_q[3]};
  assign dv_ge   = (dv_part >= {1'b0, den_q});
  assign dv_diff = dv_ge ? (dv_part - {1'b0, den_q}) : dv_part;

  // Gravity component magnitudes and the Gruneisen operand.
  logic [GravW-1:0] ax, ay, az;
  logic [GrunW-1:0] gru_src;
  logic [16:0]      gru_p1;
  logic             one_dim;
  logic             out_free;
  assign ax       = abs24(gx_q);
  assign ay       = abs24(gy_q);
  assign az       = abs24(gz_q);
  assign gru_src  = (state_q == ST_IDLE) ? in_i.gruneisen : gru_q;
  assign gru_p1   = {1'b0, gru_src} + GrunOne;
  assign one_dim  = (dims_q != DIMS_2D) && (dims_q != DIMS_3D);
  assign out_free = !out_vld_q || out_o.ready;

  assign in_i.ready      = (state_q == ST_IDLE);
  assign cfg_i.ready     = 1'b1;
  assign out_o.valid     = out_vld_q;
  assign out_o.dt_stable = out_dt_q;
  assign out_o.unlimited = out_unl_q;

  always_comb begin
    en_d       = en_q;
    dims_d     = dims_q;
    gx_d       = gx_q;
    gy_d       = gy_q;
    gz_d       = gz_q;
    state_d    = state_q;
    cnt_d      = cnt_q;
    gmag_vld_d = gmag_vld_q;
    min_d      = min_q;
    seen_d     = seen_q;
    out_vld_d  = out_vld_q;
    c_d        = c_q;
    gru_d      = gru_q;
    last_d     = last_q;
    mc_d       = mc_q;
    mp_d       = mp_q;
    acc_d      = acc_q;
    rad_d      = rad_q;
    rem_d      = rem_q;
    root_d     = root_q;
    gmag_d     = gmag_q;
    den_d      = den_q;
    drem_d     = drem_q;
    dbits_d    = dbits_q;
    quo_d      = quo_q;
    out_dt_d   = out_dt_q;
    out_unl_d  = out_unl_q;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          c_d    = in_i.cell_speed;
          gru_d  = in_i.gruneisen;
          last_d = in_i.last_cell;
          if (!en_q) begin
            state_d = ST_FIN;
          end else if (one_dim || gmag_vld_q) begin
            if (one_dim) begin
              gmag_d     = ax;
              gmag_vld_d = 1'b1;
            end
            mc_d    = {31'd0, gru_p1};
            mp_d    = {8'd0, in_i.gruneisen};
            acc_d   = 48'd0;
            cnt_d   = MulGCycles;
            state_d = ST_GMUL;
          end else begin
            mc_d    = {24'd0, ax};
            mp_d    = ax;
            acc_d   = 48'd0;
            cnt_d   = MulSqCycles;
            state_d = ST_SQX;
          end
        end
      end
      ST_SQX, ST_SQY, ST_SQZ, ST_GMUL, ST_DEN: begin
        acc_d = mul_acc;
        mc_d  = {mc_q[46:0], 1'b0};
        mp_d  = {1'b0, mp_q[23:1]};
        cnt_d = cnt_q - 6'd1;
        if (step_last) begin
          case (state_q)
            ST_SQX: begin
              mc_d    = {24'd0, ay};
              mp_d    = ay;
              cnt_d   = MulSqCycles;
              state_d = ST_SQY;
            end
            ST_SQY: begin
              if (dims_q == DIMS_3D) begin
                mc_d    = {24'd0, az};
                mp_d    = az;
                cnt_d   = MulSqCycles;
                state_d = ST_SQZ;
              end else begin
                rad_d   = mul_acc;
                rem_d   = 26'd0;
                root_d  = 24'd0;
                cnt_d   = RootGCycles;
                state_d = ST_GROOT;
              end
            end
            ST_SQZ: begin
              rad_d   = mul_acc;
              rem_d   = 26'd0;
              root_d  = 24'd0;
              cnt_d   = RootGCycles;
              state_d = ST_GROOT;
            end
            ST_GMUL: begin
              // 2*G*(G+1) is at most 34 bits; align it to the top of the radicand.
              rad_d   = {mul_acc[32:0], 15'd0};
              rem_d   = 26'd0;
              root_d  = 24'd0;
              cnt_d   = RootSCycles;
              state_d = ST_SROOT;
            end
            default: begin
              den_d   = mul_acc[40:0];
              state_d = ST_DCHK;
            end
          endcase
        end
      end
      ST_GROOT, ST_SROOT: begin
        rem_d  = rt_diff[25:0];
        root_d = rt_root;
        rad_d  = {rad_q[45:0], 2'b00};
        cnt_d  = cnt_q - 6'd1;
        if (step_last) begin
          if (state_q == ST_GROOT) begin
            gmag_d     = rt_root;
            gmag_vld_d = 1'b1;
            mc_d       = {31'd0, gru_p1};
            mp_d       = {8'd0, gru_q};
            acc_d      = 48'd0;
            cnt_d      = MulGCycles;
            state_d    = ST_GMUL;
          end else begin
            mc_d    = {24'd0, gmag_q};
            mp_d    = {7'd0, rt_root[16:0]};
            acc_d   = 48'd0;
            cnt_d   = MulDCycles;
            state_d = ST_DEN;
          end
        end
      end
      ST_DCHK: begin
        if (den_q == 41'd0) begin
          // A zero denominator sets no limit.
          state_d = ST_FIN;
        end else if ({den_q, 4'd0} <= {13'd0, c_q}) begin
          // The quotient reaches 2^32: saturate.
          quo_d   = '1;
          state_d = ST_UPD;
        end else begin
          drem_d  = {13'd0, c_q[31:4]};
          dbits_d = c_q[3:0];
          cnt_d   = DivCycles;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        drem_d  = dv_diff[40:0];
        dbits_d = {dbits_q[2:0], 1'b0};
        quo_d   = {quo_q[DtW-2:0], dv_ge};
        cnt_d   = cnt_q - 6'd1;
        if (step_last) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (quo_q < min_q) begin
          min_d = quo_q;
        end
        seen_d  = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_vld_d = 1'b1;
          out_dt_d  = en_q ? min_q : '1;
          out_unl_d = en_q ? !seen_q : 1'b1;
          min_d     = '1;
          seen_d    = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Register writes. A change of gravity or dimension invalidates |g|.
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_GRAVITY_ENABLE: en_d = cfg_i.data[0];
        CFG_NUM_DIMS: begin
          dims_d     = cfg_i.data[1:0];
          gmag_vld_d = 1'b0;
        end
        CFG_GRAVITY_X: begin
          gx_d       = cfg_i.data;
          gmag_vld_d = 1'b0;
        end
        CFG_GRAVITY_Y: begin
          gy_d       = cfg_i.data;
          gmag_vld_d = 1'b0;
        end
        CFG_GRAVITY_Z: begin
          gz_d       = cfg_i.data;
          gmag_vld_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= 1'b0;
      dims_q     <= DIMS_1D;
      gx_q       <= '0;
      gy_q       <= '0;
      gz_q       <= '0;
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      gmag_vld_q <= 1'b0;
      min_q      <= '1;
      seen_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      en_q       <= en_d;
      dims_q     <= dims_d;
      gx_q       <= gx_d;
      gy_q       <= gy_d;
      gz_q       <= gz_d;
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      gmag_vld_q <= gmag_vld_d;
      min_q      <= min_d;
      seen_q     <= seen_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q       <= c_d;
    gru_q     <= gru_d;
    last_q    <= last_d;
    mc_q      <= mc_d;
    mp_q      <= mp_d;
    acc_q     <= acc_d;
    rad_q     <= rad_d;
    rem_q     <= rem_d;
    root_q    <= root_d;
    gmag_q    <= gmag_d;
    den_q     <= den_d;
    drem_q    <= drem_d;
    dbits_q   <= dbits_d;
    quo_q     <= quo_d;
    out_dt_q  <= out_dt_d;
    out_unl_q <= out_unl_d;
  end

  // The partial remainder of the quotient always stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (drem_q < den_q))
    else $error("division remainder not below divisor");

  // The root remainder never exceeds twice the partial root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_GROOT) || (state_q == ST_SROOT)) |-> (rem_q <= {1'b0, root_q, 1'b0}))
    else $error("square root remainder out of range");

  // Without a limit in the patch the minimum stays at all ones.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (min_q == '1))
    else $error("minimum changed without a limit");

  // A finished patch loads the result and clears the running state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && last_q && out_free) |=> (!seen_q && out_vld_q))
    else $error("patch result not loaded or state not cleared");

endmodule
